FILE: sv/dss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the delimiter string splitter
// Window size, counter widths, register indexes and the job record that
// travels from the classifying front to the result sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int CHAR_CAP  = 8;
    localparam int DELIM_MAX = 8;
    localparam int CNT_W     = $clog2(CHAR_CAP + 1);
    localparam int HELD_W    = $clog2(CHAR_CAP);
    localparam int DBYTES_W  = 8 * CHAR_CAP;
    localparam int DLEN_W    = 4;
    localparam int IDX_W     = 1;

    localparam logic [IDX_W-1:0] CFG_DELIM_BYTES  = 1'd0;
    localparam logic [IDX_W-1:0] CFG_DELIM_LENGTH = 1'd1;

    typedef logic [CHAR_CAP-1:0][7:0] window_t;

    typedef struct packed {
        window_t            data;
        logic [CNT_W-1:0]   byte_cnt;
        logic               delim_hit;
        logic               string_done;
    } job_t;

endpackage
`default_nettype wire

FILE: sv/dss_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dss_in_if: string byte channel
// One beat carries an optional string byte and the end-of-string flag.
// ----------------------------------------------------------------------------
interface dss_in_if;
    logic       valid;
    logic       ready;
    logic       has_char;
    logic [7:0] char_value;
    logic       string_end;

    modport source (output valid, has_char, char_value, string_end, input ready);
    modport sink   (input valid, has_char, char_value, string_end, output ready);
endinterface
`default_nettype wire

FILE: sv/dss_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dss_out_if: token channel
// One beat carries a token byte or a token-end marker.
// ----------------------------------------------------------------------------
interface dss_out_if;
    logic       valid;
    logic       ready;
    logic       byte_present;
    logic [7:0] out_char;
    logic       token_end;
    logic       last;

    modport source (output valid, byte_present, out_char, token_end, last, input ready);
    modport sink   (input valid, byte_present, out_char, token_end, last, output ready);
endinterface
`default_nettype wire

FILE: sv/dss_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dss_front: byte classifier
// Joins held bytes with the incoming byte, compares every alignment against
// the delimiter, keeps the possible delimiter start and issues at most one job.
// ----------------------------------------------------------------------------
module dss_front
    import dss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    dss_in_if.sink                   chars,
    input  wire logic [DBYTES_W-1:0] delim_bytes,
    input  wire logic [DLEN_W-1:0]   delim_len,
    input  wire logic                push_ready,
    output logic                     push_valid,
    output job_t                     push_job
);

    logic [7:0]        held_reg  [CHAR_CAP-1];
    logic [7:0]        held_next [CHAR_CAP-1];
    logic [HELD_W-1:0] held_cnt_reg;
    logic [HELD_W-1:0] held_cnt_next;
    logic [7:0]        win [CHAR_CAP];
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  eff_len;
    logic [CNT_W-1:0]  start;
    logic [CNT_W-1:0]  rest;
    logic [CHAR_CAP:0] fit;
    logic              hit;
    logic              accept;

    assign chars.ready = push_ready;
    assign accept      = chars.valid && push_ready;

    always_comb
    begin
        logic [CNT_W-1:0] m;
        logic [CNT_W-1:0] src;

        priority if (delim_len == '0)
            eff_len = CNT_W'(1);
        else if (CNT_W'(delim_len) > CNT_W'(DELIM_MAX))
            eff_len = CNT_W'(DELIM_MAX);
        else
            eff_len = CNT_W'(delim_len);
        if (eff_len > CNT_W'(CHAR_CAP))
            eff_len = CNT_W'(CHAR_CAP);

        n = CNT_W'(held_cnt_reg) + CNT_W'(chars.has_char);
        for (int i = 0; i < CHAR_CAP; i++)
        begin
            if (i < CHAR_CAP - 1 && HELD_W'(i) < held_cnt_reg)
                win[i] = held_reg[i % (CHAR_CAP - 1)];
            else
                win[i] = chars.char_value;
        end

        for (int s = 0; s <= CHAR_CAP; s++)
        begin
            m      = n - CNT_W'(s);
            fit[s] = (CNT_W'(s) <= n) && (m <= eff_len);
            for (int i = 0; i < CHAR_CAP - s; i++)
            begin
                if (CNT_W'(i) < m && win[s + i] != delim_bytes[8*i +: 8])
                    fit[s] = 1'b0;
            end
        end

        start = CNT_W'(CHAR_CAP);
        for (int s = CHAR_CAP; s >= 0; s--)
        begin
            if (fit[s])
                start = CNT_W'(s);
        end

        rest = n - start;
        hit  = (rest == eff_len);

        for (int i = 0; i < CHAR_CAP - 1; i++)
        begin
            src          = start + CNT_W'(i);
            held_next[i] = win[src[HELD_W-1:0]];
        end
        held_cnt_next = (chars.string_end || hit) ? '0 : rest[HELD_W-1:0];

        for (int i = 0; i < CHAR_CAP; i++)
            push_job.data[i] = win[i];
        push_job.byte_cnt    = (chars.string_end && !hit) ? n : start;
        push_job.delim_hit   = hit;
        push_job.string_done = chars.string_end;
        push_valid = accept && (push_job.byte_cnt != '0 || hit || chars.string_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_cnt_reg <= '0;
        else if (accept)
            held_cnt_reg <= held_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

endmodule
`default_nettype wire

FILE: sv/dss_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dss_queue: job queue
// Short first-in first-out buffer between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module dss_queue
    import dss_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_job,
    output logic      head_valid,
    input  wire logic pop,
    output job_t      head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

FILE: sv/dss_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dss_back: result sequencer
// Walks the head job and sends its token bytes, then the delimiter marker
// and the final marker where the job has them, one beat per cycle while the output is ready.
// ----------------------------------------------------------------------------
module dss_back
    import dss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire job_t head_job,
    output logic      pop,
    dss_out_if.source tokens
);

    localparam int PW = CNT_W + 1;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] total;
    logic          done;
    logic          fire;

    assign total = PW'(head_job.byte_cnt) + PW'(head_job.delim_hit)
                 + PW'(head_job.string_done);
    assign done  = (pos_reg == total - 1'b1);
    assign fire  = head_valid && tokens.ready;
    assign pop   = fire && done;

    assign tokens.valid = head_valid;

    always_comb
    begin
        tokens.byte_present = 1'b0;
        tokens.out_char     = '0;
        tokens.token_end    = 1'b1;
        tokens.last         = 1'b1;
        if (pos_reg < PW'(head_job.byte_cnt))
        begin
            tokens.byte_present = 1'b1;
            tokens.out_char     = head_job.data[pos_reg[HELD_W-1:0]];
            tokens.token_end    = 1'b0;
            tokens.last         = 1'b0;
        end
        else if (head_job.delim_hit && pos_reg == PW'(head_job.byte_cnt))
            tokens.last = 1'b0;

        pos_next = pos_reg;
        if (fire)
            pos_next = done ? '0 : pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule
`default_nettype wire

FILE: sv/delimiter_string_splitter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delimiter_string_splitter_unit: streaming string splitter
// Cuts a byte string into tokens at a configured delimiter of 1 to 8 bytes.
// ----------------------------------------------------------------------------
// The classifier takes one string beat per cycle as long as the job queue
// has room; each beat yields 0 to 9 result beats, which the sequencer sends
// at one per cycle while the output is ready, through its single output
// port. Bytes that may start the delimiter are held inside the block and
// appear only once a match is ruled out or the string ends; every token
// closes with a byte-free token_end beat, and the last beat of a string has
// last set. Write the delimiter registers only while the block is idle.
// ----------------------------------------------------------------------------
module delimiter_string_splitter_unit
    import dss_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    dss_in_if.sink                   chars,
    dss_out_if.source                tokens,
    input  wire logic                wr_en,
    input  wire logic [IDX_W-1:0]    wr_index,
    input  wire logic [DBYTES_W-1:0] wr_data
);

    logic [DBYTES_W-1:0] delim_bytes_reg;
    logic [DLEN_W-1:0]   delim_len_reg;
    logic                push_valid;
    logic                push_ready;
    job_t                push_job;
    logic                head_valid;
    job_t                head_job;
    logic                pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_bytes_reg <= '0;
            delim_len_reg   <= DLEN_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_DELIM_BYTES:  delim_bytes_reg <= wr_data;
                CFG_DELIM_LENGTH: delim_len_reg   <= wr_data[DLEN_W-1:0];
                default:          delim_len_reg   <= delim_len_reg;
            endcase
        end
    end

    dss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .delim_bytes (delim_bytes_reg),
        .delim_len   (delim_len_reg),
        .push_ready  (push_ready),
        .push_valid  (push_valid),
        .push_job    (push_job)
    );

    dss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    dss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .tokens     (tokens)
    );

endmodule
`default_nettype wire
